// File: rtl/pn2d_pkg.sv
// Shared constants, request codes and stage-enable type for the 2-D gradient noise block.
// No dependencies; imported by pn2d_fade, perlin_noise_2d and the testbench.
package pn2d_pkg;

    localparam int TABLE_SIZE    = 256;
    localparam int IDX_W         = $clog2(TABLE_SIZE);
    localparam int COORD_W       = 24;
    localparam int OUT_W         = 19;
    localparam int FRAC_BITS_DEF = 16;
    localparam int OUT_MAX       = 262143;
    localparam int OUT_MIN       = -262144;

    // request codes on the func field
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // advance strobes for the three registered stages of the fade unit
    typedef struct packed {
        logic stage_a;
        logic stage_b;
        logic stage_c;
    } fade_en_t;

endpackage

// File: rtl/perlin_noise_2d.sv
// Evaluate results reach noise_value through the stage registers; one request per cycle while not stalled.
// Load requests write the permutation table and give no result; an evaluate right behind
// a load sees the new entry, since each table copy is written at the stage that reads it.
// Five 256 x 8 table copies (one write, two reads each) carry the ten lookups of a request.
// Reset clears the pipeline valid bits only; table contents are undefined until loaded.
// Depends on pn2d_pkg and pn2d_fade.
module perlin_noise_2d
    import pn2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [IDX_W-1:0]         table_index,
    input  logic [IDX_W-1:0]         table_value,
    input  logic [COORD_W-1:0]       coord_x,
    input  logic [COORD_W-1:0]       coord_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  noise_value
);

    localparam int W    = FRAC_BITS;
    localparam int GW   = W + 3;
    localparam int SW   = (GW > OUT_W) ? GW : OUT_W;
    localparam int NSTG = 8;
    localparam logic signed [GW-1:0] ONE_G  = GW'(1) << W;
    localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

    function automatic logic signed [GW-1:0] grad_fn(
        input logic [3:0]           h,
        input logic signed [GW-1:0] gx,
        input logic signed [GW-1:0] gy
    );
        logic signed [GW-1:0] u;
        logic signed [GW-1:0] v;
        u = (h < 4'd8) ? gx : gy;
        if (h < 4'd4)
            v = gy;
        else if (h inside {4'd12, 4'd14})
            v = gx;
        else
            v = '0;
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    // stage advance and valid chain
    logic [NSTG-1:0] en;
    logic [NSTG:1]   vld_reg;
    logic [NSTG:1]   vld_next;

    // input decode
    logic [COORD_W+IDX_W-1:0] cx_w;
    logic [COORD_W+IDX_W-1:0] cy_w;
    logic [IDX_W-1:0]         xi;
    logic [IDX_W-1:0]         xi1;
    logic [IDX_W-1:0]         yi;
    logic [W-1:0]             xf;
    logic [W-1:0]             yf;

    // table copies and their read registers
    logic [IDX_W-1:0] mem0 [TABLE_SIZE];
    logic [IDX_W-1:0] mem1 [TABLE_SIZE];
    logic [IDX_W-1:0] mem2 [TABLE_SIZE];
    logic [IDX_W-1:0] mem3 [TABLE_SIZE];
    logic [IDX_W-1:0] mem4 [TABLE_SIZE];
    logic [IDX_W-1:0] m0_rd_a_reg, m0_rd_b_reg;
    logic [IDX_W-1:0] m1_rd_a_reg, m1_rd_b_reg;
    logic [IDX_W-1:0] m2_rd_a_reg, m2_rd_b_reg;
    logic [IDX_W-1:0] m3_rd_a_reg, m3_rd_b_reg;
    logic [IDX_W-1:0] m4_rd_a_reg, m4_rd_b_reg;

    // stage 1
    logic             s1_func_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic [IDX_W-1:0] s1_val_reg;
    logic [IDX_W-1:0] s1_yi_reg;
    logic [W-1:0]     s1_xf_reg;
    logic [W-1:0]     s1_yf_reg;
    logic [IDX_W-1:0] a_addr, a1_addr, b_addr, b1_addr;

    // stage 2
    logic             s2_func_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [IDX_W-1:0] s2_val_reg;
    logic [W-1:0]     s2_xf_reg;
    logic [W-1:0]     s2_yf_reg;

    // stage 3
    logic [W-1:0]     s3_xf_reg;
    logic [W-1:0]     s3_yf_reg;
    fade_en_t         fade_en;
    logic [W:0]       fade_x;
    logic [W:0]       fade_y;
    logic signed [GW-1:0] x0_s, x1_s, y0_s, y1_s;

    // stage 4
    logic signed [GW-1:0] s4_gaa_next, s4_gab_next, s4_gba_next, s4_gbb_next;
    logic signed [GW-1:0] s4_gaa_reg, s4_gab_reg, s4_gba_reg, s4_gbb_reg;
    logic [W:0]           s4_u_reg;
    logic [W:0]           s4_v_reg;

    // stage 5
    logic signed [GW:0]     d1, d2;
    logic signed [2*W+5:0]  s5_p1_next, s5_p2_next;
    logic signed [2*W+5:0]  s5_p1_reg, s5_p2_reg;
    logic signed [GW-1:0]   s5_gaa_reg, s5_gab_reg;
    logic [W:0]             s5_v_reg;

    // stage 6
    logic signed [GW-1:0] s6_x1_next, s6_x2_next;
    logic signed [GW-1:0] s6_x1_reg, s6_x2_reg;
    logic [W:0]           s6_v_reg;

    // stage 7
    logic signed [GW:0]    d3;
    logic signed [2*W+5:0] s7_p3_next;
    logic signed [2*W+5:0] s7_p3_reg;
    logic signed [GW-1:0]  s7_x1_reg;

    // output register
    logic signed [GW-1:0]    r_val;
    logic signed [SW-1:0]    r_w;
    logic signed [OUT_W-1:0] out_noise_next;
    logic signed [OUT_W-1:0] out_noise_reg;

    // a stage moves on when the next one is empty or moving on itself
    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG] || !out_stall;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !vld_reg[i+1] || en[i+1];
    end

    always_comb
    begin
        vld_next[1] = en[0] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NSTG; i++)
            vld_next[i] = en[i-1] ? vld_reg[i-1] : vld_reg[i];
        // load requests end once the last table copies are written
        vld_next[3] = en[2] ? (vld_reg[2] && (s2_func_reg == FUNC_EVAL)) : vld_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall    = !en[0];
    assign out_valid   = vld_reg[NSTG];
    assign noise_value = out_noise_reg;

    // integer part wraps to the table size
    always_comb
    begin
        cx_w = {{IDX_W{1'b0}}, coord_x};
        cy_w = {{IDX_W{1'b0}}, coord_y};
        xi   = cx_w[W +: IDX_W];
        yi   = cy_w[W +: IDX_W];
        xi1  = xi + IDX_W'(1);
        xf   = coord_x[W-1:0];
        yf   = coord_y[W-1:0];
    end

    always_comb
    begin
        a_addr  = m0_rd_a_reg + s1_yi_reg;
        a1_addr = a_addr + IDX_W'(1);
        b_addr  = m0_rd_b_reg + s1_yi_reg;
        b1_addr = b_addr + IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en[0] && in_valid && (func == FUNC_LOAD))
            mem0[table_index] <= table_value;
        if (en[0])
        begin
            m0_rd_a_reg <= mem0[xi];
            m0_rd_b_reg <= mem0[xi1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1] && vld_reg[1] && (s1_func_reg == FUNC_LOAD))
            mem1[s1_idx_reg] <= s1_val_reg;
        if (en[1])
        begin
            m1_rd_a_reg <= mem1[a_addr];
            m1_rd_b_reg <= mem1[a1_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1] && vld_reg[1] && (s1_func_reg == FUNC_LOAD))
            mem2[s1_idx_reg] <= s1_val_reg;
        if (en[1])
        begin
            m2_rd_a_reg <= mem2[b_addr];
            m2_rd_b_reg <= mem2[b1_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2] && vld_reg[2] && (s2_func_reg == FUNC_LOAD))
            mem3[s2_idx_reg] <= s2_val_reg;
        if (en[2])
        begin
            m3_rd_a_reg <= mem3[m1_rd_a_reg];
            m3_rd_b_reg <= mem3[m1_rd_b_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2] && vld_reg[2] && (s2_func_reg == FUNC_LOAD))
            mem4[s2_idx_reg] <= s2_val_reg;
        if (en[2])
        begin
            m4_rd_a_reg <= mem4[m2_rd_a_reg];
            m4_rd_b_reg <= mem4[m2_rd_b_reg];
        end
    end

    assign fade_en = '{stage_a: en[0], stage_b: en[1], stage_c: en[2]};

    pn2d_fade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fade_x (
        .clk  (clk),
        .en   (fade_en),
        .frac (xf),
        .fade (fade_x)
    );

    pn2d_fade #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fade_y (
        .clk  (clk),
        .en   (fade_en),
        .frac (yf),
        .fade (fade_y)
    );

    // corner offsets and gradients
    always_comb
    begin
        x0_s = $signed(GW'(s3_xf_reg));
        y0_s = $signed(GW'(s3_yf_reg));
        x1_s = x0_s - ONE_G;
        y1_s = y0_s - ONE_G;
        s4_gaa_next = grad_fn(m3_rd_a_reg[3:0], x0_s, y0_s);
        s4_gab_next = grad_fn(m3_rd_b_reg[3:0], x0_s, y1_s);
        s4_gba_next = grad_fn(m4_rd_a_reg[3:0], x1_s, y0_s);
        s4_gbb_next = grad_fn(m4_rd_b_reg[3:0], x1_s, y1_s);
    end

    // lerps along x, then along y
    always_comb
    begin
        d1 = (GW+1)'(s4_gba_reg) - (GW+1)'(s4_gaa_reg);
        d2 = (GW+1)'(s4_gbb_reg) - (GW+1)'(s4_gab_reg);
        s5_p1_next = $signed({1'b0, s4_u_reg}) * d1;
        s5_p2_next = $signed({1'b0, s4_u_reg}) * d2;
        s6_x1_next = s5_gaa_reg + GW'(s5_p1_reg >>> W);
        s6_x2_next = s5_gab_reg + GW'(s5_p2_reg >>> W);
        d3 = (GW+1)'(s6_x2_reg) - (GW+1)'(s6_x1_reg);
        s7_p3_next = $signed({1'b0, s6_v_reg}) * d3;
    end

    // clamp to the output range
    always_comb
    begin
        r_val = s7_x1_reg + GW'(s7_p3_reg >>> W);
        r_w   = SW'(r_val);
        if (r_w > SAT_HI)
            r_w = SAT_HI;
        else if (r_w < SAT_LO)
            r_w = SAT_LO;
        out_noise_next = OUT_W'(r_w);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_func_reg <= func;
            s1_idx_reg  <= table_index;
            s1_val_reg  <= table_value;
            s1_yi_reg   <= yi;
            s1_xf_reg   <= xf;
            s1_yf_reg   <= yf;
        end
        if (en[1])
        begin
            s2_func_reg <= s1_func_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_val_reg  <= s1_val_reg;
            s2_xf_reg   <= s1_xf_reg;
            s2_yf_reg   <= s1_yf_reg;
        end
        if (en[2])
        begin
            s3_xf_reg <= s2_xf_reg;
            s3_yf_reg <= s2_yf_reg;
        end
        if (en[3])
        begin
            s4_gaa_reg <= s4_gaa_next;
            s4_gab_reg <= s4_gab_next;
            s4_gba_reg <= s4_gba_next;
            s4_gbb_reg <= s4_gbb_next;
            s4_u_reg   <= fade_x;
            s4_v_reg   <= fade_y;
        end
        if (en[4])
        begin
            s5_p1_reg  <= s5_p1_next;
            s5_p2_reg  <= s5_p2_next;
            s5_gaa_reg <= s4_gaa_reg;
            s5_gab_reg <= s4_gab_reg;
            s5_v_reg   <= s4_v_reg;
        end
        if (en[5])
        begin
            s6_x1_reg <= s6_x1_next;
            s6_x2_reg <= s6_x2_next;
            s6_v_reg  <= s5_v_reg;
        end
        if (en[6])
        begin
            s7_p3_reg <= s7_p3_next;
            s7_x1_reg <= s6_x1_reg;
        end
        if (en[7])
        begin
            out_noise_reg <= out_noise_next;
        end
    end

endmodule

// File: rtl/pn2d_fade.sv
// Three-stage fade polynomial 6t^5 - 15t^4 + 10t^3 on an unsigned fraction.
// Depends on pn2d_pkg (fade_en_t, FRAC_BITS_DEF).
module pn2d_fade
    import pn2d_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  fade_en_t             en,
    input  logic [FRAC_BITS-1:0] frac,
    output logic [FRAC_BITS:0]   fade
);

    localparam int W = FRAC_BITS;
    localparam logic signed [W+4:0]   K15 = (W+5)'(15) << W;
    localparam logic signed [2*W+5:0] K10 = (2*W+6)'(10) << W;

    logic signed [W+4:0]   frac_s;
    logic signed [W+4:0]   lin;
    logic signed [2*W+5:0] p1_next;
    logic [2*W-1:0]        p2_next;
    logic [W+3:0]          s_next;
    logic [2*W-1:0]        p3_next;
    logic [2*W+3:0]        p4_next;

    logic signed [2*W+5:0] p1_reg;
    logic [2*W-1:0]        p2_reg;
    logic [W-1:0]          t_reg;
    logic [W+3:0]          s_reg;
    logic [2*W-1:0]        p3_reg;
    logic [2*W+3:0]        p4_reg;

    assign frac_s = $signed((W+5)'(frac));
    assign lin    = (frac_s <<< 2) + (frac_s <<< 1) - K15;

    always_comb
    begin
        p1_next = $signed({1'b0, frac}) * lin;
        p2_next = frac * frac;
        // floor of a signed product is an arithmetic shift
        s_next  = (W+4)'((p1_reg >>> W) + K10);
        p3_next = p2_reg[2*W-1:W] * t_reg;
        p4_next = p3_reg[2*W-1:W] * s_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.stage_a)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            t_reg  <= frac;
        end
        if (en.stage_b)
        begin
            s_reg  <= s_next;
            p3_reg <= p3_next;
        end
        if (en.stage_c)
        begin
            p4_reg <= p4_next;
        end
    end

    assign fade = p4_reg[2*W:W];

endmodule

// File: test/tb_perlin_noise_2d.sv
// Self-checking testbench for perlin_noise_2d: fills the permutation table, then drives directed
// and random load/evaluate requests, partly under random idling, and checks each noise value.
// Depends on pn2d_pkg and the perlin_noise_2d RTL.
import pn2d_pkg::*;

localparam longint Q_ONE = longint'(1) << FRAC_BITS_DEF;

class noise_scoreboard;
    bit [7:0]                perm_copy [TABLE_SIZE];
    logic signed [OUT_W-1:0] pending_noise [$];
    int unsigned             loads;
    int unsigned             evals;
    int unsigned             checked;
    int unsigned             errors;

    // floor of the scaled product; arithmetic shift rounds toward minus infinity
    function longint scaled_mul(longint a, longint b);
        return (a * b) >>> FRAC_BITS_DEF;
    endfunction

    function longint fade(longint t);
        longint s;
        longint c;
        s = scaled_mul(t, 6 * t - 15 * Q_ONE) + 10 * Q_ONE;
        c = scaled_mul(scaled_mul(t, t), t);
        return scaled_mul(c, s);
    endfunction

    function longint blend(longint a, longint b, longint w);
        return a + scaled_mul(w, b - a);
    endfunction

    function longint slope(bit [7:0] hash, longint dx, longint dy);
        bit [3:0] h;
        longint   u;
        longint   v;
        h = hash[3:0];
        u = (h < 4'd8) ? dx : dy;
        v = (h < 4'd4) ? dy : ((h == 4'd12 || h == 4'd14) ? dx : 0);
        if (h[0])
            u = -u;
        if (h[1])
            v = -v;
        return u + v;
    endfunction

    function logic signed [OUT_W-1:0] noise_at(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        bit [7:0] xi, yi, xi1, a, a1, b, b1;
        longint   xf, yf, fu, fv, g_aa, g_ab, g_ba, g_bb, row0, row1, r;
        xi   = 8'(x >> FRAC_BITS_DEF);
        yi   = 8'(y >> FRAC_BITS_DEF);
        xf   = longint'(x) & (Q_ONE - 1);
        yf   = longint'(y) & (Q_ONE - 1);
        fu   = fade(xf);
        fv   = fade(yf);
        // keep every hash index at 8 bits so it wraps like the table
        xi1  = xi + 8'd1;
        a    = perm_copy[xi] + yi;
        b    = perm_copy[xi1] + yi;
        a1   = a + 8'd1;
        b1   = b + 8'd1;
        g_aa = slope(perm_copy[perm_copy[a]], xf, yf);
        g_ab = slope(perm_copy[perm_copy[a1]], xf, yf - Q_ONE);
        g_ba = slope(perm_copy[perm_copy[b]], xf - Q_ONE, yf);
        g_bb = slope(perm_copy[perm_copy[b1]], xf - Q_ONE, yf - Q_ONE);
        row0 = blend(g_aa, g_ba, fu);
        row1 = blend(g_ab, g_bb, fu);
        r    = blend(row0, row1, fv);
        if (r > OUT_MAX)
            r = OUT_MAX;
        if (r < OUT_MIN)
            r = OUT_MIN;
        return OUT_W'(r);
    endfunction

    function void note_request(logic f, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val,
                               logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        if (f == FUNC_LOAD)
        begin
            perm_copy[idx] = val;
            loads++;
        end
        else
        begin
            pending_noise.push_back(noise_at(x, y));
            evals++;
        end
    endfunction

    function void check_result(logic signed [OUT_W-1:0] actual);
        logic signed [OUT_W-1:0] want;
        if (pending_noise.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected noise_value %0d with no evaluate pending", actual);
            return;
        end
        want = pending_noise.pop_front();
        checked++;
        if (actual !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("noise_value mismatch on result %0d: expected %0d, got %0d",
                         checked, want, actual);
        end
    endfunction
endclass

module tb_perlin_noise_2d;
    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    func;
    logic [IDX_W-1:0]        table_index;
    logic [IDX_W-1:0]        table_value;
    logic [COORD_W-1:0]      coord_x;
    logic [COORD_W-1:0]      coord_y;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] noise_value;

    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic            hold_flag     = 1'b0;
    noise_scoreboard sb            = new;

    perlin_noise_2d i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .table_index (table_index),
        .table_value (table_value),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .noise_value (noise_value)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver: random stalls, or a solid hold-off while hold_flag is up
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_flag)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
                sb.note_request(func, table_index, table_value, coord_x, coord_y);
            if (out_valid && !out_stall)
                sb.check_result(noise_value);
        end
    end

    task automatic send_request(input logic f, input logic [IDX_W-1:0] idx,
                                input logic [IDX_W-1:0] val,
                                input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        table_index <= idx;
        table_value <= val;
        coord_x     <= x;
        coord_y     <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // coordinate fields ride along with random content on a load
    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] val);
        send_request(FUNC_LOAD, idx, val, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic eval_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        send_request(FUNC_EVAL, IDX_W'($urandom), IDX_W'($urandom), x, y);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            1: return {8'($urandom), 16'h0000};
            2: return {8'($urandom), 16'hFFFF};
            3: return {8'hFF, 16'($urandom)};
            4: return {8'($urandom), 16'($urandom_range(0, 15))};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic random_requests(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15)
                load_entry(IDX_W'($urandom), IDX_W'($urandom));
            else
                eval_point(pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        int unsigned i;
        int          wait_cycles;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= FUNC_LOAD;
        table_index <= '0;
        table_value <= '0;
        coord_x     <= '0;
        coord_y     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write every entry before any evaluate can read it
        for (i = 0; i < TABLE_SIZE; i++)
            load_entry(IDX_W'(i), IDX_W'($urandom));

        load_entry(8'h00, 8'h00);
        load_entry(8'hFF, 8'hFF);
        eval_point(24'h000000, 24'h000000);
        eval_point(24'hFFFFFF, 24'hFFFFFF);
        eval_point(24'h00FFFF, 24'h000000);
        eval_point(24'h000000, 24'h00FFFF);
        eval_point(24'h008000, 24'h008000);
        eval_point(24'hFF8000, 24'h018000);
        eval_point(24'h7FFFFF, 24'h800000);
        eval_point(24'hAA5555, 24'h55AAAA);
        eval_point(24'h010000, 24'hFF0001);
        // rewrite an entry and read it back on the very next request
        load_entry(8'hFE, 8'h5A);
        eval_point(24'hFE4000, 24'h03C000);
        load_entry(8'h5A, 8'hA5);
        eval_point(24'hFDFFFF, 24'h5A0001);
        eval_point(24'hFF0000, 24'hFFFFFF);

        send_idle_pct = 16;
        recv_idle_pct <= 82;
        random_requests(560);

        send_idle_pct = 82;
        recv_idle_pct <= 16;
        random_requests(460);

        // hold the output long enough for the pipe to fill and stall its input
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        fork
            begin
                hold_flag <= 1'b1;
                repeat (300) @(posedge clk);
                hold_flag <= 1'b0;
            end
            random_requests(60);
        join

        random_requests(560);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_noise.size() != 0 && wait_cycles < 4000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (16) @(posedge clk);
        if (sb.pending_noise.size() != 0)
            $display("%0d noise values never arrived", sb.pending_noise.size());
        sb.errors += sb.pending_noise.size();

        $display("Run covered %0d table loads and %0d evaluates, %0d noise values checked;",
                 sb.loads, sb.evals, sb.checked);
        $display("idling on both sides, swapped, then none, plus a 300-cycle output hold-off.");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout: block stopped accepting requests or returning results");
        $display("TB_ERROR");
        $finish;
    end
endmodule

// File: perlin_noise_2d.f
rtl/pn2d_pkg.sv
rtl/pn2d_fade.sv
rtl/perlin_noise_2d.sv
test/tb_perlin_noise_2d.sv
